### src/drfs_pkg.sv
// shared types and constants for the rectangle fill command streamer
// no dependencies; used by the interfaces, the engine and the top level
package drfs_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_PAGE_SET = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEM_WRITE = 8'h2C;

    localparam logic OP_START = 1'b0;
    localparam logic OP_READY = 1'b1;

    localparam logic ORIENT_PORTRAIT = 1'b0;
    localparam logic ORIENT_LANDSCAPE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIENTATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_SIDE = 2'd1;

    localparam logic [COORD_W-1:0] LONG_SIDE_RESET = 16'd320;

    typedef enum logic [3:0] {
        STEP_COL_CMD   = 4'd0,
        STEP_COL0_HI   = 4'd1,
        STEP_COL0_LO   = 4'd2,
        STEP_COL1_HI   = 4'd3,
        STEP_COL1_LO   = 4'd4,
        STEP_PAGE_CMD  = 4'd5,
        STEP_PAGE0_HI  = 4'd6,
        STEP_PAGE0_LO  = 4'd7,
        STEP_PAGE1_HI  = 4'd8,
        STEP_PAGE1_LO  = 4'd9,
        STEP_MEM_WRITE = 4'd10,
        STEP_PIXEL     = 4'd11
    } step_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] length;
        logic [COORD_W-1:0] rows;
        logic [COORD_W-1:0] colour;
    } rect_t;

    typedef struct packed {
        logic               orientation;
        logic [COORD_W-1:0] long_side;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              is_data;
        logic              last;
    } result_t;

endpackage

### src/drfs_if.sv
// channel interfaces: rectangle/ready input, byte output, register writes
// depends on drfs_pkg for widths
interface drfs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [drfs_pkg::COORD_W-1:0] start_x;
    logic [drfs_pkg::COORD_W-1:0] start_y;
    logic [drfs_pkg::COORD_W-1:0] run_length;
    logic [drfs_pkg::COORD_W-1:0] row_total;
    logic [drfs_pkg::COORD_W-1:0] colour;

    modport source (
        output valid, cmd, start_x, start_y, run_length, row_total, colour,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, run_length, row_total, colour,
        output ready
    );
endinterface

interface drfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [drfs_pkg::BYTE_W-1:0] byte_out;
    logic                        is_data;
    logic                        last;

    modport source (
        output valid, byte_out, is_data, last,
        input  ready
    );
    modport sink (
        input  valid, byte_out, is_data, last,
        output ready
    );
endinterface

interface drfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [drfs_pkg::CFG_INDEX_W-1:0] index;
    logic [drfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### src/drfs_engine.sv
// rectangle state and byte sequencer: one byte per accepted ready word while busy
// depends on drfs_pkg
module drfs_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cmd,
    input  drfs_pkg::rect_t   rect,
    input  drfs_pkg::cfg_t    cfg,
    output logic              res_valid,
    output drfs_pkg::result_t res,
    output logic              busy
);

    logic                         busy_reg, busy_next;
    logic [drfs_pkg::COORD_W-1:0] row_index_reg, row_index_next;
    drfs_pkg::step_t              step_reg, step_next;
    logic [drfs_pkg::COORD_W-1:0] pixel_index_reg, pixel_index_next;
    logic                         low_half_reg, low_half_next;
    drfs_pkg::rect_t              held_reg, held_next;

    logic [drfs_pkg::COORD_W-1:0] row_y;
    logic [drfs_pkg::COORD_W-1:0] col0, col1, page0, page1;
    logic [drfs_pkg::COORD_W-1:0] row_inc, pixel_inc;
    logic                         row_end;

    assign row_y = held_reg.y + row_index_reg;
    assign row_inc = row_index_reg + 16'd1;
    assign pixel_inc = pixel_index_reg + 16'd1;

    // landscape swaps axes and mirrors pages against the long side
    always_comb
    begin
        if (cfg.orientation == drfs_pkg::ORIENT_PORTRAIT)
        begin
            col0 = held_reg.x;
            col1 = held_reg.x + held_reg.length;
            page0 = row_y;
            page1 = row_y;
        end
        else
        begin
            col0 = row_y;
            col1 = row_y;
            page0 = cfg.long_side - held_reg.x - held_reg.length;
            page1 = cfg.long_side - held_reg.x;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        row_index_next = row_index_reg;
        step_next = step_reg;
        pixel_index_next = pixel_index_reg;
        low_half_next = low_half_reg;
        held_next = held_reg;
        res_valid = 1'b0;
        res.byte_out = drfs_pkg::CMD_MEM_WRITE;
        res.is_data = 1'b1;
        res.last = 1'b0;
        row_end = 1'b0;

        if (cmd == drfs_pkg::OP_START)
        begin
            if (!busy_reg)
            begin
                held_next = rect;
                row_index_next = '0;
                step_next = drfs_pkg::STEP_COL_CMD;
                pixel_index_next = '0;
                low_half_next = 1'b0;
                busy_next = (rect.rows != '0);
            end
        end
        else if (busy_reg)
        begin
            res_valid = 1'b1;
            unique case (step_reg)
                drfs_pkg::STEP_COL_CMD:
                begin
                    res.byte_out = drfs_pkg::CMD_COLUMN_SET;
                    res.is_data = 1'b0;
                    step_next = drfs_pkg::STEP_COL0_HI;
                end
                drfs_pkg::STEP_COL0_HI:
                begin
                    res.byte_out = col0[15:8];
                    step_next = drfs_pkg::STEP_COL0_LO;
                end
                drfs_pkg::STEP_COL0_LO:
                begin
                    res.byte_out = col0[7:0];
                    step_next = drfs_pkg::STEP_COL1_HI;
                end
                drfs_pkg::STEP_COL1_HI:
                begin
                    res.byte_out = col1[15:8];
                    step_next = drfs_pkg::STEP_COL1_LO;
                end
                drfs_pkg::STEP_COL1_LO:
                begin
                    res.byte_out = col1[7:0];
                    step_next = drfs_pkg::STEP_PAGE_CMD;
                end
                drfs_pkg::STEP_PAGE_CMD:
                begin
                    res.byte_out = drfs_pkg::CMD_PAGE_SET;
                    res.is_data = 1'b0;
                    step_next = drfs_pkg::STEP_PAGE0_HI;
                end
                drfs_pkg::STEP_PAGE0_HI:
                begin
                    res.byte_out = page0[15:8];
                    step_next = drfs_pkg::STEP_PAGE0_LO;
                end
                drfs_pkg::STEP_PAGE0_LO:
                begin
                    res.byte_out = page0[7:0];
                    step_next = drfs_pkg::STEP_PAGE1_HI;
                end
                drfs_pkg::STEP_PAGE1_HI:
                begin
                    res.byte_out = page1[15:8];
                    step_next = drfs_pkg::STEP_PAGE1_LO;
                end
                drfs_pkg::STEP_PAGE1_LO:
                begin
                    res.byte_out = page1[7:0];
                    step_next = drfs_pkg::STEP_MEM_WRITE;
                end
                drfs_pkg::STEP_MEM_WRITE:
                begin
                    res.byte_out = drfs_pkg::CMD_MEM_WRITE;
                    res.is_data = 1'b0;
                    if (held_reg.length == '0)
                    begin
                        row_end = 1'b1;
                    end
                    else
                    begin
                        step_next = drfs_pkg::STEP_PIXEL;
                    end
                end
                default:
                begin
                    if (!low_half_reg)
                    begin
                        res.byte_out = held_reg.colour[15:8];
                        low_half_next = 1'b1;
                    end
                    else
                    begin
                        res.byte_out = held_reg.colour[7:0];
                        low_half_next = 1'b0;
                        pixel_index_next = pixel_inc;
                        row_end = (pixel_inc == held_reg.length);
                    end
                end
            endcase

            if (row_end)
            begin
                row_index_next = row_inc;
                step_next = drfs_pkg::STEP_COL_CMD;
                pixel_index_next = '0;
                low_half_next = 1'b0;
                if (row_inc == held_reg.rows)
                begin
                    busy_next = 1'b0;
                    res.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_index_reg <= '0;
            step_reg <= drfs_pkg::STEP_COL_CMD;
            pixel_index_reg <= '0;
            low_half_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= busy_next;
            row_index_reg <= row_index_next;
            step_reg <= step_next;
            pixel_index_reg <= pixel_index_next;
            low_half_reg <= low_half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    assign busy = busy_reg;

endmodule

### src/display_rect_fill_streamer.sv
// Rectangle fill command streamer. A start word latches a rectangle when idle;
// every later ready word yields one byte of the column-set, page-set, memory-write
// header for each row, followed by the colour bytes of every pixel. One word
// is taken per clock while the output is not stalled: the byte is computed
// combinationally from the held rectangle and row counters and lands in an output
// register, and a new word is taken whenever that register is empty or drained in
// the same cycle. Register writes are always ready.
// depends on drfs_pkg, drfs_if and drfs_engine
module display_rect_fill_streamer (
    input logic        clk,
    input logic        rst_n,
    drfs_in_if.sink    stream_in,
    drfs_out_if.source stream_out,
    drfs_cfg_if.sink   cfg
);

    logic                         orientation_reg;
    logic [drfs_pkg::COORD_W-1:0] long_side_reg;
    logic                         out_valid_reg;
    drfs_pkg::result_t            out_data_reg;

    drfs_pkg::rect_t   rect;
    drfs_pkg::cfg_t    cfg_now;
    drfs_pkg::result_t res;
    logic              res_valid;
    logic              in_accept;
    logic              busy;

    assign rect.x = stream_in.start_x;
    assign rect.y = stream_in.start_y;
    assign rect.length = stream_in.run_length;
    assign rect.rows = stream_in.row_total;
    assign rect.colour = stream_in.colour;

    assign cfg_now.orientation = orientation_reg;
    assign cfg_now.long_side = long_side_reg;

    assign stream_in.ready = !out_valid_reg || stream_out.ready;
    assign in_accept = stream_in.valid && stream_in.ready;

    drfs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .cmd       (stream_in.cmd),
        .rect      (rect),
        .cfg       (cfg_now),
        .res_valid (res_valid),
        .res       (res),
        .busy      (busy)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= drfs_pkg::ORIENT_LANDSCAPE;
            long_side_reg <= drfs_pkg::LONG_SIDE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                drfs_pkg::CFG_ORIENTATION: orientation_reg <= cfg.data[0];
                drfs_pkg::CFG_LONG_SIDE:   long_side_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // output register, refilled in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stream_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign stream_out.valid = out_valid_reg;
    assign stream_out.byte_out = out_data_reg.byte_out;
    assign stream_out.is_data = out_data_reg.is_data;
    assign stream_out.last = out_data_reg.last;

    // a start word never produces a byte
    a_start_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && stream_in.cmd == drfs_pkg::OP_START
        |=> out_valid_reg == $past(out_valid_reg && !stream_out.ready))
        else $error("start word produced an output byte");

    // input stalls only behind a full output register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !stream_in.ready |-> out_valid_reg)
        else $error("input stalled with empty output register");

    // a final command byte can only be the memory-write command
    a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.last && !out_data_reg.is_data
        |-> out_data_reg.byte_out == drfs_pkg::CMD_MEM_WRITE)
        else $error("last flag on a header byte other than memory write");

    // the final byte of a rectangle leaves the engine idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res_valid && res.last |=> !busy)
        else $error("engine still busy after last byte");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for display_rect_fill_streamer: random start and ready words,
// a scoreboard class that predicts every output byte, and random stalls on the input and output channels
// depends on drfs_pkg, drfs_if and the display_rect_fill_streamer rtl
module testbench;

    localparam int unsigned RANDOM_WORDS = 1950;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_CYCLES = 8;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_KINDS = 7;

    class fill_byte_board;
        logic                          orient;
        logic [drfs_pkg::COORD_W-1:0]  long_side;
        bit                            busy;
        logic [drfs_pkg::COORD_W-1:0]  row_idx;
        drfs_pkg::step_t               step;
        logic [drfs_pkg::COORD_W-1:0]  pix_idx;
        bit                            low_next;
        drfs_pkg::rect_t               held;
        drfs_pkg::result_t             expected_q[$];
        int unsigned                   errors;
        int unsigned                   checked;

        function new();
            orient = drfs_pkg::ORIENT_LANDSCAPE;
            long_side = drfs_pkg::LONG_SIDE_RESET;
            busy = 1'b0;
            row_idx = '0;
            step = drfs_pkg::STEP_COL_CMD;
            pix_idx = '0;
            low_next = 1'b0;
            held = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [drfs_pkg::CFG_INDEX_W-1:0] idx,
                                logic [drfs_pkg::CFG_DATA_W-1:0] value);
            if (idx == drfs_pkg::CFG_ORIENTATION)
                orient = value[0];
            else if (idx == drfs_pkg::CFG_LONG_SIDE)
                long_side = value;
        endfunction

        function logic [drfs_pkg::BYTE_W-1:0] header_byte(drfs_pkg::step_t s,
                                                          output logic is_data);
            logic [drfs_pkg::COORD_W-1:0] row_y;
            logic [drfs_pkg::COORD_W-1:0] c0;
            logic [drfs_pkg::COORD_W-1:0] c1;
            logic [drfs_pkg::COORD_W-1:0] p0;
            logic [drfs_pkg::COORD_W-1:0] p1;
            row_y = held.y + row_idx;
            if (orient == drfs_pkg::ORIENT_PORTRAIT)
            begin
                c0 = held.x;
                c1 = held.x + held.length;
                p0 = row_y;
                p1 = row_y;
            end
            else
            begin
                c0 = row_y;
                c1 = row_y;
                p0 = long_side - held.x - held.length;
                p1 = long_side - held.x;
            end
            is_data = 1'b1;
            case (s)
                drfs_pkg::STEP_COL_CMD:
                begin
                    is_data = 1'b0;
                    return drfs_pkg::CMD_COLUMN_SET;
                end
                drfs_pkg::STEP_COL0_HI:  return c0[15:8];
                drfs_pkg::STEP_COL0_LO:  return c0[7:0];
                drfs_pkg::STEP_COL1_HI:  return c1[15:8];
                drfs_pkg::STEP_COL1_LO:  return c1[7:0];
                drfs_pkg::STEP_PAGE_CMD:
                begin
                    is_data = 1'b0;
                    return drfs_pkg::CMD_PAGE_SET;
                end
                drfs_pkg::STEP_PAGE0_HI: return p0[15:8];
                drfs_pkg::STEP_PAGE0_LO: return p0[7:0];
                drfs_pkg::STEP_PAGE1_HI: return p1[15:8];
                drfs_pkg::STEP_PAGE1_LO: return p1[7:0];
                default:
                begin
                    is_data = 1'b0;
                    return drfs_pkg::CMD_MEM_WRITE;
                end
            endcase
        endfunction

        // returns 1 when the word changed anything
        function bit note_word(logic op, drfs_pkg::rect_t r);
            drfs_pkg::result_t res;
            bit row_done;
            if (op == drfs_pkg::OP_START)
            begin
                if (busy)
                    return 1'b0;
                held = r;
                row_idx = '0;
                step = drfs_pkg::STEP_COL_CMD;
                pix_idx = '0;
                low_next = 1'b0;
                busy = (r.rows != '0);
                return 1'b1;
            end
            if (!busy)
                return 1'b0;
            row_done = 1'b0;
            if (step != drfs_pkg::STEP_PIXEL)
            begin
                res.byte_out = header_byte(step, res.is_data);
                if (step == drfs_pkg::STEP_MEM_WRITE)
                begin
                    if (held.length == '0)
                        row_done = 1'b1;
                    else
                        step = drfs_pkg::STEP_PIXEL;
                end
                else
                    step = drfs_pkg::step_t'(step + 4'd1);
            end
            else
            begin
                res.is_data = 1'b1;
                if (!low_next)
                begin
                    res.byte_out = held.colour[15:8];
                    low_next = 1'b1;
                end
                else
                begin
                    res.byte_out = held.colour[7:0];
                    low_next = 1'b0;
                    pix_idx = pix_idx + 16'd1;
                    if (pix_idx == held.length)
                        row_done = 1'b1;
                end
            end
            res.last = 1'b0;
            if (row_done)
            begin
                row_idx = row_idx + 16'd1;
                step = drfs_pkg::STEP_COL_CMD;
                pix_idx = '0;
                low_next = 1'b0;
                if (row_idx == held.rows)
                begin
                    busy = 1'b0;
                    res.last = 1'b1;
                end
            end
            expected_q.push_back(res);
            return 1'b1;
        endfunction

        function void check_byte(logic [drfs_pkg::BYTE_W-1:0] got_byte, logic got_data,
                                 logic got_last);
            drfs_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("byte 0x%h arrived with nothing expected", got_byte);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got_byte !== want.byte_out)
            begin
                $error("byte_out: expected 0x%h, got 0x%h", want.byte_out, got_byte);
                errors++;
            end
            if (got_data !== want.is_data)
            begin
                $error("is_data: expected %b, got %b", want.is_data, got_data);
                errors++;
            end
            if (got_last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit no_idle;
    int unsigned used_words;
    int unsigned rect_count;
    int unsigned reg_writes;
    int unsigned quiet_cycles;
    fill_byte_board board = new();

    drfs_in_if in_ch();
    drfs_out_if out_ch();
    drfs_cfg_if cfg_ch();

    display_rect_fill_streamer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream_in  (in_ch),
        .stream_out (out_ch),
        .cfg        (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic drfs_pkg::rect_t make_rect(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] len, logic [15:0] rows,
                                                  logic [15:0] colour);
        drfs_pkg::rect_t r;
        r.x = x;
        r.y = y;
        r.length = len;
        r.rows = rows;
        r.colour = colour;
        return r;
    endfunction

    function automatic drfs_pkg::rect_t noise_rect();
        return make_rect(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
    endfunction

    function automatic logic [15:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 16'h0000;
        if (r < 24)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic drfs_pkg::rect_t rand_rect();
        int unsigned r;
        logic [15:0] len;
        logic [15:0] rows;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 16'($urandom_range(0, 4));
        else if (r < 95)
            len = 16'($urandom_range(5, 24));
        else
            len = 16'($urandom_range(25, 120));
        r = $urandom_range(0, 99);
        if (r < 5)
            rows = 16'd0;
        else if (r < 80)
            rows = 16'($urandom_range(1, 3));
        else
            rows = 16'($urandom_range(4, 8));
        return make_rect(pick_coord(), pick_coord(), len, rows, 16'($urandom));
    endfunction

    // leaves valid high so a following word can go out back to back
    task automatic send_word(logic op, drfs_pkg::rect_t r);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= op;
        in_ch.start_x <= r.x;
        in_ch.start_y <= r.y;
        in_ch.run_length <= r.length;
        in_ch.row_total <= r.rows;
        in_ch.colour <= r.colour;
        do @(posedge clk); while (!in_ch.ready);
        if (board.note_word(op, r))
        begin
            used_words++;
            if (op == drfs_pkg::OP_START && r.rows != '0)
                rect_count++;
        end
    endtask

    task automatic send_ready();
        send_word(drfs_pkg::OP_READY, noise_rect());
    endtask

    task automatic finish_rect(int unsigned noise_pct);
        while (board.busy)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(drfs_pkg::OP_START, noise_rect());
            send_ready();
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(logic orient, logic [15:0] side);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= drfs_pkg::CFG_ORIENTATION;
        cfg_ch.data <= {15'd0, orient};
        do @(posedge clk); while (!cfg_ch.ready);
        board.write_reg(drfs_pkg::CFG_ORIENTATION, {15'd0, orient});
        cfg_ch.index <= drfs_pkg::CFG_LONG_SIDE;
        cfg_ch.data <= side;
        do @(posedge clk); while (!cfg_ch.ready);
        board.write_reg(drfs_pkg::CFG_LONG_SIDE, side);
        cfg_ch.valid <= 1'b0;
        reg_writes += 2;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random stalls, with stretches of steady ready
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int unsigned stall;
            stall = gap_len();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_byte(out_ch.byte_out, out_ch.is_data, out_ch.last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic        phase_orient[PHASE_KINDS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic [15:0] phase_side[PHASE_KINDS] =
            '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'd320, 16'd0, 16'd0};
        int unsigned phase;
        int unsigned k;
        logic [15:0] side;

        rst_n <= 1'b0;
        no_idle = 1'b0;
        used_words = 0;
        rect_count = 0;
        reg_writes = 0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= drfs_pkg::OP_READY;
        in_ch.start_x <= '0;
        in_ch.start_y <= '0;
        in_ch.run_length <= '0;
        in_ch.row_total <= '0;
        in_ch.colour <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= drfs_pkg::CFG_ORIENTATION;
        cfg_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle ready, zero rows, ignored start, zero length, wraps
        send_ready();
        send_word(drfs_pkg::OP_START,
                  make_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_ready();
        send_word(drfs_pkg::OP_START, make_rect(16'd10, 16'd20, 16'd2, 16'd2, 16'hF81F));
        repeat (3) send_ready();
        send_word(drfs_pkg::OP_START,
                  make_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(drfs_pkg::OP_START,
                  make_rect(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        finish_rect(0);
        send_word(drfs_pkg::OP_START, make_rect(16'd0, 16'd5, 16'd0, 16'd1, 16'h07E0));
        finish_rect(0);
        drain();
        write_settings(drfs_pkg::ORIENT_PORTRAIT, 16'hFFFF);
        send_word(drfs_pkg::OP_START, make_rect(16'hFFFF, 16'hFFFF, 16'd1, 16'd2, 16'h0000));
        finish_rect(0);
        drain();
        write_settings(drfs_pkg::ORIENT_LANDSCAPE, 16'h0000);
        send_word(drfs_pkg::OP_START, make_rect(16'hFFFF, 16'h8000, 16'd1, 16'd1, 16'hFFFF));
        finish_rect(0);
        drain();

        phase = 0;
        while (used_words < RANDOM_WORDS)
        begin
            k = phase % PHASE_KINDS;
            side = (k >= 5) ? 16'($urandom) : phase_side[k];
            write_settings(phase_orient[k], side);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10))
            begin
                if (used_words < RANDOM_WORDS)
                begin
                    if ($urandom_range(0, 99) < 10)
                        send_ready();
                    send_word(drfs_pkg::OP_START, rand_rect());
                    finish_rect(4);
                end
            end
            drain();
            phase++;
        end

        no_idle = 1'b0;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (END_CYCLES) @(posedge clk);
        $display("drew %0d rectangles over %0d register settings, %0d bytes checked",
                 rect_count, phase + 3, board.checked);
        $display("%0d effective words, %0d register writes", used_words, reg_writes);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
